@@ sv/gaussian_pdf_cdf_unit_assert.svh @@
// Assertion macros shared by the Gaussian density and distribution unit.
`ifndef GAUSSIAN_PDF_CDF_UNIT_ASSERT_SVH
`define GAUSSIAN_PDF_CDF_UNIT_ASSERT_SVH

// Condition that must hold at every clock edge out of reset.
`define GPC_ASSERT_ALWAYS(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("gpc invariant violated");

// Condition that must hold in the same cycle as its trigger.
`define GPC_ASSERT_IMPLIES(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("gpc implication violated");

`endif

@@ sv/gpc_pkg.sv @@
// Shared types, constants and fixed-point helpers of the Gaussian unit.
package gpc_pkg;

   localparam int EXP_TABLE_DEPTH_DEFAULT = 256;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCOUNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int HORNER_TERMS = 13;

   // register indexes
   localparam logic CSR_MEAN = 1'b0;
   localparam logic CSR_INV_SIGMA = 1'b1;

   localparam logic [31:0] MEAN_RESET = 32'd0;
   localparam logic [31:0] INV_SIGMA_RESET = 32'd65536;

   localparam logic [30:0] ONE_Q30 = 31'd1073741824;
   localparam logic [29:0] LN2_Q30 = 30'd744261118;
   localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
   localparam logic [28:0] INV_SQRT2PI_Q30 = 29'd428361012;
   localparam logic [27:0] B0_Q30 = 28'd248723606;
   localparam logic signed [33:0] B1_Q30 = 34'sd342933307;
   localparam logic signed [33:0] B2_Q30 = -34'sd382857446;
   localparam logic signed [33:0] B3_Q30 = 34'sd1912847370;
   localparam logic signed [33:0] B4_Q30 = -34'sd1955558716;
   localparam logic signed [33:0] B5_Q30 = 34'sd1428371292;
   localparam logic [16:0] ONE_Q16 = 17'd65536;
   localparam logic [5:0] EXP_SHIFT_LIMIT = 6'd40;

   // one queued item: sign of x - mean, far-tail flag, |z| in Q4.28
   typedef struct packed {
      logic        neg;
      logic        far;
      logic [31:0] z;
   } gpc_entry_type;

   typedef struct packed {
      logic          valid;
      gpc_entry_type entry;
   } gpc_push_type;

   typedef struct packed {
      logic [QCOUNT_W-1:0] count;
      logic                empty;
   } gpc_queue_status_type;

   // floor(2^30 / k) for the Horner divisors
   function automatic logic [30:0] recip(input int k);
      logic [30:0] r;
      case (k)
         1:       r = 31'd1073741824;
         2:       r = 31'd536870912;
         3:       r = 31'd357913941;
         4:       r = 31'd268435456;
         5:       r = 31'd214748364;
         6:       r = 31'd178956970;
         7:       r = 31'd153391689;
         8:       r = 31'd134217728;
         9:       r = 31'd119304647;
         10:      r = 31'd107374182;
         11:      r = 31'd97612893;
         12:      r = 31'd89478485;
         13:      r = 31'd82595524;
         default: r = 31'd1073741824;
      endcase
      return r;
   endfunction

   // AS 26.2.17 coefficients b1..b5
   function automatic logic signed [33:0] coef(input int k);
      logic signed [33:0] c;
      case (k)
         1:       c = B1_Q30;
         2:       c = B2_Q30;
         3:       c = B3_Q30;
         4:       c = B4_Q30;
         default: c = B5_Q30;
      endcase
      return c;
   endfunction

   // quotient estimate by reciprocal, at most one low
   function automatic logic [29:0] recip_mul(input logic [29:0] p, input int k);
      logic [60:0] pr;
      pr = 61'(p) * 61'(recip(k));
      return 30'(pr >> 30);
   endfunction

   // fix the estimate up to the exact floor(p / k)
   function automatic logic [29:0] div_fix(input logic [29:0] p, input logic [29:0] q0,
                                           input int k);
      logic [33:0] bk;
      logic [33:0] rr;
      bk = 34'(q0) * 34'(k);
      rr = 34'(p) - bk;
      return (rr >= 34'(k)) ? q0 + 30'd1 : q0;
   endfunction

   // signed Q.30 times unsigned Q.30, truncated toward zero
   function automatic logic signed [33:0] smul(input logic signed [33:0] x,
                                               input logic [30:0] b);
      logic [33:0] m;
      logic [64:0] pr;
      logic [33:0] mag;
      m = x[33] ? 34'(-x) : 34'(x);
      pr = 65'(m) * 65'(b);
      mag = 34'(pr >> 30);
      return x[33] ? -$signed(mag) : $signed(mag);
   endfunction

   // exp(-a) Taylor series by Horner, used to build the table
   function automatic logic [30:0] exp_poly(input logic [29:0] a);
      logic [30:0] acc;
      logic [60:0] pr;
      logic [29:0] p;
      acc = ONE_Q30;
      for (int k = HORNER_TERMS; k >= 1; k--) begin
         pr = 61'(a) * 61'(acc);
         p = 30'(pr >> 30);
         acc = ONE_Q30 - 31'(div_fix(p, recip_mul(p, k), k));
      end
      return acc;
   endfunction

   // table entry i: 2^(-i/depth) in Q.30, depth = 2^iw
   function automatic logic [30:0] rom_entry(input int i, input int iw);
      logic [63:0] pr;
      pr = 64'(i) * 64'(LN2_Q30);
      return exp_poly(30'(pr >> iw));
   endfunction

endpackage

@@ sv/gpc_front.sv @@
// Front end: standardizes the sample, flags far tails and pushes items to the queue.
module gpc_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [31:0]                  req_sample_x,
   input  logic [31:0]                  mean_value,
   input  logic [31:0]                  inv_sigma,
   input  gpc_pkg::gpc_queue_status_type q_status,
   output gpc_pkg::gpc_push_type        push
);
   import gpc_pkg::*;

   logic               f1_valid_ff, f1_valid_in;
   logic               f1_neg_ff, f1_neg_in;
   logic [32:0]        f1_mag_ff, f1_mag_in;
   logic               f2_valid_ff;
   logic               f2_neg_ff;
   logic [64:0]        f2_prod_ff, f2_prod_in;
   logic signed [32:0] diff;
   logic [QCOUNT_W+1:0] committed;
   logic               accept;

   // room check counts items still in flight toward the queue
   assign committed = (QCOUNT_W + 2)'(q_status.count) + (QCOUNT_W + 2)'(f1_valid_ff)
                      + (QCOUNT_W + 2)'(f2_valid_ff);
   assign req_stall = committed >= (QCOUNT_W + 2)'(QUEUE_DEPTH);
   assign accept = req_valid && !req_stall;

   // x - mean at 33 bits, then magnitude
   always_comb begin
      diff = $signed({req_sample_x[31], req_sample_x}) - $signed({mean_value[31], mean_value});
      f1_valid_in = accept;
      f1_neg_in = diff[32];
      f1_mag_in = diff[32] ? 33'(-diff) : 33'(diff);
      f2_prod_in = 65'(f1_mag_ff) * 65'(inv_sigma);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
         f2_valid_ff <= 1'b0;
      end else begin
         f1_valid_ff <= f1_valid_in;
         f2_valid_ff <= f1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      f1_neg_ff <= f1_neg_in;
      f1_mag_ff <= f1_mag_in;
      f2_neg_ff <= f1_neg_ff;
      f2_prod_ff <= f2_prod_in;
   end

   // classify: |z| above eight is a far tail
   always_comb begin
      push.valid = f2_valid_ff;
      push.entry.neg = f2_neg_ff;
      push.entry.far = f2_prod_ff > (65'd1 << 35);
      push.entry.z = f2_prod_ff[35:4];
   end
endmodule

@@ sv/gpc_queue.sv @@
// Short item queue between the front end and the arithmetic back end.
module gpc_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  gpc_pkg::gpc_push_type         push,
   input  logic                          pop,
   output gpc_pkg::gpc_entry_type        head,
   output gpc_pkg::gpc_queue_status_type status
);
   import gpc_pkg::*;

   gpc_entry_type       mem [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCOUNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = push.valid ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in = count_ff + QCOUNT_W'(push.valid) - QCOUNT_W'(pop);
      head = mem[rd_ptr_ff];
      status.count = count_ff;
      status.empty = count_ff == '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         mem[wr_ptr_ff] <= push.entry;
      end
   end
endmodule

@@ sv/gpc_back.sv @@
// Back end: pipelined exp, reciprocal, tail polynomial and result formatting.
module gpc_back #(
   parameter int EXP_TABLE_DEPTH = gpc_pkg::EXP_TABLE_DEPTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [31:0]                   inv_sigma,
   input  gpc_pkg::gpc_entry_type        head,
   input  gpc_pkg::gpc_queue_status_type q_status,
   output logic                          pop,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [31:0]                   rsp_density,
   output logic [16:0]                   rsp_cumulative
);
   import gpc_pkg::*;

   localparam int IW = $clog2(EXP_TABLE_DEPTH);
   // op schedule, one register stage per op
   localparam int OP_U = 0;
   localparam int OP_V = 1;
   localparam int OP_SPLIT = 2;
   localparam int OP_ROM = 3;
   localparam int H0 = 4;
   localparam int H_END = H0 + 3 * HORNER_TERMS;
   localparam int DIV0 = 2;
   localparam int DIV_BITS = 31;
   localparam int P0 = DIV0 + DIV_BITS;
   localparam int P_LAST = P0 + 8;
   localparam int OP_MUL_E = H_END;
   localparam int OP_SHIFT = H_END + 1;
   localparam int OP_PHI = H_END + 2;
   localparam int OP_DENS = H_END + 3;
   localparam int OP_FINAL = H_END + 4;
   localparam int NUM_OPS = H_END + 5;

   typedef struct packed {
      logic               neg;
      logic               far;
      logic [31:0]        z;
      logic [33:0]        u;
      logic [59:0]        dprod;
      logic [33:0]        v;
      logic [5:0]         n;
      logic [IW-1:0]      idx;
      logic [27:0]        rem;
      logic [30:0]        romv;
      logic [29:0]        a;
      logic [30:0]        acc;
      logic [29:0]        p;
      logic [29:0]        q0;
      logic [30:0]        den;
      logic [31:0]        divr;
      logic [30:0]        quo;
      logic signed [33:0] c;
      logic signed [33:0] w;
      logic [30:0]        e;
      logic [30:0]        phi;
      logic [31:0]        dens;
      logic signed [33:0] tail;
      logic [16:0]        cum;
   } stage_type;

   logic [30:0]      rom_tbl [EXP_TABLE_DEPTH];
   stage_type        stage_ff [NUM_OPS + 1];
   stage_type        stage_in [NUM_OPS + 1];
   logic [NUM_OPS:0] valid_ff;
   logic             adv;

   // constant table of 2^(-i/depth)
   for (genvar i = 0; i < EXP_TABLE_DEPTH; i++) begin : g_rom
      assign rom_tbl[i] = rom_entry(i, IW);
   end

   // whole pipe moves unless a finished item is held
   assign adv = !(valid_ff[NUM_OPS] && rsp_stall);
   assign pop = adv && !q_status.empty;

   always_comb begin
      stage_in[0] = '0;
      stage_in[0].neg = head.neg;
      stage_in[0].far = head.far;
      stage_in[0].z = head.z;
   end

   for (genvar s = 0; s < NUM_OPS; s++) begin : g_op
      localparam int HSTEP = (s - H0) / 3;
      localparam int HPHASE = (s - H0) % 3;
      localparam int HK = HORNER_TERMS - HSTEP;
      localparam int PPHASE = (s - P0) % 2;
      localparam int PK = 4 - (s - P0 - 1) / 2;

      always_comb begin
         stage_type   nx;
         logic [63:0] pu;
         logic [64:0] pv;
         logic [57:0] pa;
         logic [60:0] hp;
         logic [61:0] pe;
         logic [59:0] pphi;
         logic [62:0] pdens;
         logic [31:0] r2;
         logic [30:0] tc;
         logic [31:0] csum;
         nx = stage_ff[s];
         pu = '0;
         pv = '0;
         pa = '0;
         hp = '0;
         pe = '0;
         pphi = '0;
         pdens = '0;
         r2 = '0;
         tc = '0;
         csum = '0;

         // z^2/2 and b0*z
         if (s == OP_U) begin
            pu = 64'(nx.z) * 64'(nx.z);
            nx.u = 34'(pu >> 29);
            nx.dprod = 60'(B0_Q30) * 60'(nx.z);
         end
         // scale to base two, set up the divider and polynomial
         if (s == OP_V) begin
            pv = 65'(nx.u) * 65'(LOG2E_Q30);
            nx.v = 34'(pv >> 30);
            nx.den = (31'd1 << 28) + 31'(nx.dprod >> 30);
            nx.divr = 32'd1 << 27;
            nx.quo = '0;
            nx.c = B5_Q30;
         end
         // integer part, table index and residual
         if (s == OP_SPLIT) begin
            nx.n = nx.v[33:28];
            nx.idx = nx.v[27 -: IW];
            nx.rem = nx.v[27:0] << IW;
         end
         if (s == OP_ROM) begin
            nx.romv = rom_tbl[nx.idx];
            pa = 58'(nx.rem) * 58'(LN2_Q30);
            nx.a = 30'(pa >> (28 + IW));
            nx.acc = ONE_Q30;
         end
         // Horner step: multiply, reciprocal estimate, fix-up
         if (s >= H0 && s < H_END) begin
            if (HPHASE == 0) begin
               hp = 61'(nx.a) * 61'(nx.acc);
               nx.p = 30'(hp >> 30);
            end else if (HPHASE == 1) begin
               nx.q0 = recip_mul(nx.p, HK);
            end else begin
               nx.acc = ONE_Q30 - 31'(div_fix(nx.p, nx.q0, HK));
            end
         end
         // restoring division for t = 2^58 / den, one bit per stage
         if (s >= DIV0 && s < P0) begin
            r2 = {nx.divr[30:0], 1'b0};
            if (r2 >= {1'b0, nx.den}) begin
               nx.divr = r2 - {1'b0, nx.den};
               nx.quo = {nx.quo[29:0], 1'b1};
            end else begin
               nx.divr = r2;
               nx.quo = {nx.quo[29:0], 1'b0};
            end
         end
         // tail polynomial in t
         if (s >= P0 && s <= P_LAST) begin
            if (PPHASE == 0) begin
               nx.w = smul(nx.c, nx.quo);
            end else begin
               nx.c = coef(PK) + nx.w;
            end
         end
         if (s == OP_MUL_E) begin
            pe = 62'(nx.romv) * 62'(nx.acc);
            nx.e = 31'(pe >> 30);
         end
         if (s == OP_SHIFT) begin
            nx.e = (nx.n >= EXP_SHIFT_LIMIT) ? '0 : nx.e >> nx.n;
         end
         if (s == OP_PHI) begin
            pphi = 60'(nx.e) * 60'(INV_SQRT2PI_Q30);
            nx.phi = 31'(pphi >> 30);
         end
         // density and tail probability
         if (s == OP_DENS) begin
            pdens = 63'(nx.phi) * 63'(inv_sigma);
            nx.dens = (pdens[62:62] != '0 || pdens[61:30] > 32'hFFFF_FFFF) ?
                      32'hFFFF_FFFF : pdens[61:30];
            nx.tail = smul(nx.w, nx.phi);
         end
         // clamp, mirror, round to Q.16; far tails override
         if (s == OP_FINAL) begin
            if (nx.tail[33]) begin
               tc = '0;
            end else if (nx.tail > $signed({3'b000, ONE_Q30})) begin
               tc = ONE_Q30;
            end else begin
               tc = nx.tail[30:0];
            end
            if (!nx.neg) begin
               tc = ONE_Q30 - tc;
            end
            csum = 32'(tc) + (32'd1 << 13);
            nx.cum = (csum[31:14] > 18'(ONE_Q16)) ? ONE_Q16 : csum[30:14];
            if (nx.far) begin
               nx.dens = '0;
               nx.cum = nx.neg ? '0 : ONE_Q16;
            end
         end
         stage_in[s + 1] = nx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[NUM_OPS-1:0], pop};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i <= NUM_OPS; i++) begin
            stage_ff[i] <= stage_in[i];
         end
      end
   end

   assign rsp_valid = valid_ff[NUM_OPS];
   assign rsp_density = stage_ff[NUM_OPS].dens;
   assign rsp_cumulative = stage_ff[NUM_OPS].cum;
endmodule

@@ sv/gaussian_pdf_cdf_unit.sv @@
// Top level of the Gaussian density and cumulative-distribution unit.
//
// Takes one signed Q16.16 sample per clock and returns the normal density
// (Q16.16) and the Abramowitz-Stegun cumulative probability (Q1.16). A
// front end forms z = (x - mean) * inv_sigma over two stages and flags
// |z| > 8; a four-item queue feeds a 48-stage back end that evaluates exp
// through a constant table plus a 13-term Horner chain (three stages a
// term), computes t = 1/(1 + b0|z|) with a one-bit-per-stage divider and
// runs the tail polynomial alongside. Throughput is one item per cycle
// while rsp_stall is low, since a held result freezes the whole back end;
// the back-end depth is set by the Horner chain. EXP_TABLE_DEPTH must be a
// power of two. The table is constant, so there is no clearing pass after
// reset. Write mean_value and inv_sigma only while no items are in flight.
module gaussian_pdf_cdf_unit #(
   parameter int EXP_TABLE_DEPTH = gpc_pkg::EXP_TABLE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_sample_x,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_density,
   output logic [16:0] rsp_cumulative,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [31:0] csr_write_data
);
   import gpc_pkg::*;
`include "gaussian_pdf_cdf_unit_assert.svh"

   logic [31:0]          mean_ff, mean_in;
   logic [31:0]          inv_sigma_ff, inv_sigma_in;
   gpc_push_type         push;
   gpc_entry_type        head;
   gpc_queue_status_type q_status;
   logic                 q_pop;

   // configuration registers
   always_comb begin
      mean_in = mean_ff;
      inv_sigma_in = inv_sigma_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_MEAN:      mean_in = csr_write_data;
            CSR_INV_SIGMA: inv_sigma_in = csr_write_data;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mean_ff <= MEAN_RESET;
         inv_sigma_ff <= INV_SIGMA_RESET;
      end else begin
         mean_ff <= mean_in;
         inv_sigma_ff <= inv_sigma_in;
      end
   end

   gpc_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_sample_x (req_sample_x),
      .mean_value   (mean_ff),
      .inv_sigma    (inv_sigma_ff),
      .q_status     (q_status),
      .push         (push)
   );

   gpc_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .pop    (q_pop),
      .head   (head),
      .status (q_status)
   );

   gpc_back #(
      .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .inv_sigma      (inv_sigma_ff),
      .head           (head),
      .q_status       (q_status),
      .pop            (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_density    (rsp_density),
      .rsp_cumulative (rsp_cumulative)
   );

   // queue never holds more than its depth
   `GPC_ASSERT_ALWAYS(a_queue_bound, q_status.count <= QCOUNT_W'(QUEUE_DEPTH))
   // a push into a full queue must coincide with a pop
   `GPC_ASSERT_IMPLIES(a_no_overflow, push.valid && q_status.count == QCOUNT_W'(QUEUE_DEPTH), q_pop)
   // a pop only happens with something queued
   `GPC_ASSERT_IMPLIES(a_no_underflow, q_pop, !q_status.empty)
   // probabilities stay within one
   `GPC_ASSERT_IMPLIES(a_cum_range, rsp_valid, rsp_cumulative <= ONE_Q16)
endmodule
